>>> rtl/wfot_pkg.sv
package wfot_pkg;

   localparam int MAX_ROWS  = 1024;
   localparam int SCORE_W   = 16;
   localparam int MODE_W    = 3;
   localparam int CNT_W     = $clog2(MAX_ROWS + 1);
   // worst case |sum| is MAX_ROWS * 2^15, plus a sign bit
   localparam int SUM_W     = SCORE_W + CNT_W;
   localparam int PROD_W    = CNT_W + 1 + SCORE_W;
   localparam int TOT_W     = SUM_W + 2;
   localparam int NUM_W     = TOT_W + 2;
   localparam int FRAC_W    = 17;
   localparam int DIV_W     = NUM_W + FRAC_W + 1;
   localparam int REM_W     = NUM_W + 1;
   localparam int STEP_W    = $clog2(DIV_W);
   localparam int RATIO_W   = 32;
   localparam int REG_IDX_W = 2;
   localparam int CSR_W     = 16;

   localparam logic [MODE_W-1:0] MODE_RAW    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UNDER  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ABS    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LMIN   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_GSHIFT = 3'd4;

   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_WEIGHT_MODE  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_GLOBAL_SHIFT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOTAL,
      ST_PREP,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accumulate;
      logic calc_total;
      logic prep;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic zero_total;
   } status_type;

endpackage

>>> rtl/wfot_req_if.sv
interface wfot_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [wfot_pkg::SCORE_W-1:0] score;
   logic                                last_row;

   modport source (output valid, score, last_row, input ready);
   modport sink   (input valid, score, last_row, output ready);
endinterface

>>> rtl/wfot_rsp_if.sv
interface wfot_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [wfot_pkg::RATIO_W-1:0] ratio;
   logic                                zero_total;
   logic                                saturated;

   modport source (output valid, ratio, zero_total, saturated, input ready);
   modport sink   (input valid, ratio, zero_total, saturated, output ready);
endinterface

>>> rtl/weighted_fraction_over_threshold_top.sv
// Weighted fraction over threshold: takes one signed score per row (one row per cycle while
// idle) and, on the row flagged last_row, returns the column's over weight divided by its total
// weight (two minus that in MODE_UNDER) as signed Q15.16 with zero_total and saturated flags.
// Rows are summed as they are accepted; after the last row the block computes the totals, sets
// up a 49-step bit-serial restoring divider, runs it and loads the result, skipping the divider
// when the total is zero, and accepts no row during that time. The result sits in an output
// register, so the next column can start while it waits to be taken; a column that ends while
// an earlier result is still pending holds its result load, and with it the input, until that
// result is taken. Configuration is written through csr_we/csr_index/csr_wdata while idle;
// that is the user's duty, which the block itself leaves unenforced.
module weighted_fraction_over_threshold_top (
   input  logic                             clock,
   input  logic                             reset,
   wfot_req_if.sink                         req_ch,
   wfot_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [wfot_pkg::REG_IDX_W-1:0]   csr_index,
   input  logic [wfot_pkg::CSR_W-1:0]       csr_wdata
);

   wfot_pkg::cmd_type    cmd;
   wfot_pkg::status_type sts;

   wfot_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_last_row (req_ch.last_row),
      .req_ready    (req_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .sts          (sts),
      .cmd          (cmd)
   );

   wfot_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .score      (req_ch.score),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ratio      (rsp_ch.ratio),
      .zero_total (rsp_ch.zero_total),
      .saturated  (rsp_ch.saturated)
   );

   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result register overwritten while pending");

   a_last_starts_total: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.last_row) |=> cmd.calc_total)
      else $error("column end did not start totals");

   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.zero_total) |-> (rsp_ch.ratio == '0 && !rsp_ch.saturated))
      else $error("zero total result not clean");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || cmd.prep || cmd.calc_total) |-> !cmd.accumulate)
      else $error("row accumulated during column finish");

endmodule

>>> rtl/wfot_datapath.sv
module wfot_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wfot_pkg::cmd_type                    cmd,
   output wfot_pkg::status_type                 sts,
   input  logic signed [wfot_pkg::SCORE_W-1:0]  score,
   input  logic                                 csr_we,
   input  logic [wfot_pkg::REG_IDX_W-1:0]       csr_index,
   input  logic [wfot_pkg::CSR_W-1:0]           csr_wdata,
   output logic signed [wfot_pkg::RATIO_W-1:0]  ratio,
   output logic                                 zero_total,
   output logic                                 saturated
);

   localparam int SW = wfot_pkg::SCORE_W;

   logic signed [SW-1:0]                      threshold_ff;
   logic [wfot_pkg::MODE_W-1:0]               weight_mode_ff;
   logic signed [SW-1:0]                      global_shift_ff;

   logic signed [wfot_pkg::SUM_W-1:0]         sum_all_ff, sum_all_in;
   logic signed [wfot_pkg::SUM_W-1:0]         sum_over_ff, sum_over_in;
   logic [wfot_pkg::CNT_W-1:0]                count_all_ff, count_all_in;
   logic [wfot_pkg::CNT_W-1:0]                count_over_ff, count_over_in;
   logic signed [SW-1:0]                      column_min_ff, column_min_in;

   logic signed [wfot_pkg::TOT_W-1:0]         total_ff, total_in;
   logic signed [wfot_pkg::TOT_W-1:0]         over_ff, over_in;

   logic [wfot_pkg::DIV_W-1:0]                quo_ff, quo_in;
   logic [wfot_pkg::REM_W-1:0]                rem_ff, rem_in;
   logic [wfot_pkg::REM_W-1:0]                dvsr_ff, dvsr_in;
   logic                                      neg_ff, neg_in;

   logic signed [wfot_pkg::RATIO_W-1:0]       ratio_ff, ratio_in;
   logic                                      zero_ff, zero_in;
   logic                                      sat_ff, sat_in;

   logic signed [SW:0]                        score_x, weight;
   logic                                      take, is_over;
   logic signed [SW-1:0]                      shift;
   logic signed [wfot_pkg::PROD_W-1:0]        prod_all, prod_over;
   logic signed [wfot_pkg::NUM_W-1:0]         num, den;
   logic [wfot_pkg::NUM_W-1:0]                mag_num, mag_den;
   logic [wfot_pkg::REM_W:0]                  trial;
   logic [wfot_pkg::DIV_W-1:0]                quo_clip;
   logic                                      clip;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= '0;
         weight_mode_ff  <= wfot_pkg::MODE_RAW;
         global_shift_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            wfot_pkg::REG_THRESHOLD:    threshold_ff    <= csr_wdata;
            wfot_pkg::REG_WEIGHT_MODE:  weight_mode_ff  <= csr_wdata[wfot_pkg::MODE_W-1:0];
            wfot_pkg::REG_GLOBAL_SHIFT: global_shift_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // row accumulation
   always_comb begin
      score_x = {score[SW-1], score};
      weight  = (weight_mode_ff == wfot_pkg::MODE_ABS && score[SW-1]) ? -score_x : score_x;
      is_over = score >= threshold_ff;
      take    = cmd.accumulate
                && (count_all_ff < wfot_pkg::CNT_W'(wfot_pkg::MAX_ROWS))
                && (weight_mode_ff <= wfot_pkg::MODE_GSHIFT);

      sum_all_in    = sum_all_ff;
      sum_over_in   = sum_over_ff;
      count_all_in  = count_all_ff;
      count_over_in = count_over_ff;
      column_min_in = column_min_ff;
      if (cmd.calc_total) begin
         sum_all_in    = '0;
         sum_over_in   = '0;
         count_all_in  = '0;
         count_over_in = '0;
         column_min_in = {1'b0, {(SW-1){1'b1}}};
      end else if (take) begin
         sum_all_in   = sum_all_ff + wfot_pkg::SUM_W'(weight);
         count_all_in = count_all_ff + 1'b1;
         if (is_over) begin
            sum_over_in   = sum_over_ff + wfot_pkg::SUM_W'(weight);
            count_over_in = count_over_ff + 1'b1;
         end
         if (score < column_min_ff)
            column_min_in = score;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_all_ff    <= '0;
         sum_over_ff   <= '0;
         count_all_ff  <= '0;
         count_over_ff <= '0;
         column_min_ff <= {1'b0, {(SW-1){1'b1}}};
      end else begin
         sum_all_ff    <= sum_all_in;
         sum_over_ff   <= sum_over_in;
         count_all_ff  <= count_all_in;
         count_over_ff <= count_over_in;
         column_min_ff <= column_min_in;
      end
   end

   // column totals: weight = score - shift summed as sum - count * shift
   always_comb begin
      case (weight_mode_ff)
         wfot_pkg::MODE_LMIN:   shift = column_min_ff;
         wfot_pkg::MODE_GSHIFT: shift = global_shift_ff;
         default:               shift = '0;
      endcase
      prod_all  = $signed({1'b0, count_all_ff}) * shift;
      prod_over = $signed({1'b0, count_over_ff}) * shift;
      total_in  = cmd.calc_total
                  ? wfot_pkg::TOT_W'(sum_all_ff) - wfot_pkg::TOT_W'(prod_all) : total_ff;
      over_in   = cmd.calc_total
                  ? wfot_pkg::TOT_W'(sum_over_ff) - wfot_pkg::TOT_W'(prod_over) : over_ff;
   end

   // divider setup and restoring steps, one quotient bit per cycle
   always_comb begin
      if (weight_mode_ff == wfot_pkg::MODE_UNDER)
         num = (wfot_pkg::NUM_W'(total_ff) <<< 1) - wfot_pkg::NUM_W'(over_ff);
      else
         num = wfot_pkg::NUM_W'(over_ff);
      den     = wfot_pkg::NUM_W'(total_ff);
      mag_num = num[wfot_pkg::NUM_W-1] ? wfot_pkg::NUM_W'(-num) : wfot_pkg::NUM_W'(num);
      mag_den = den[wfot_pkg::NUM_W-1] ? wfot_pkg::NUM_W'(-den) : wfot_pkg::NUM_W'(den);
      trial   = {rem_ff, quo_ff[wfot_pkg::DIV_W-1]};

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      neg_in  = neg_ff;
      if (cmd.prep) begin
         // (a * 2^17 + b) / (2b) rounds half away from zero
         quo_in  = wfot_pkg::DIV_W'({mag_num, {wfot_pkg::FRAC_W{1'b0}}})
                   + wfot_pkg::DIV_W'(mag_den);
         rem_in  = '0;
         dvsr_in = {mag_den, 1'b0};
         neg_in  = num[wfot_pkg::NUM_W-1] ^ den[wfot_pkg::NUM_W-1];
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = wfot_pkg::REM_W'(trial - {1'b0, dvsr_ff});
            quo_in = {quo_ff[wfot_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[wfot_pkg::REM_W-1:0];
            quo_in = {quo_ff[wfot_pkg::DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      over_ff  <= over_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
      neg_ff   <= neg_in;
   end

   // clip to Q15.16 and form the result
   always_comb begin
      if (neg_ff)
         clip = quo_ff > wfot_pkg::DIV_W'(64'h8000_0000);
      else
         clip = quo_ff > wfot_pkg::DIV_W'(64'h7FFF_FFFF);
      if (clip)
         quo_clip = neg_ff ? wfot_pkg::DIV_W'(64'h8000_0000) : wfot_pkg::DIV_W'(64'h7FFF_FFFF);
      else
         quo_clip = quo_ff;

      ratio_in = ratio_ff;
      zero_in  = zero_ff;
      sat_in   = sat_ff;
      if (cmd.load_out) begin
         if (sts.zero_total) begin
            ratio_in = '0;
            zero_in  = 1'b1;
            sat_in   = 1'b0;
         end else begin
            ratio_in = neg_ff ? wfot_pkg::RATIO_W'(32'd0 - quo_clip[wfot_pkg::RATIO_W-1:0])
                              : quo_clip[wfot_pkg::RATIO_W-1:0];
            zero_in  = 1'b0;
            sat_in   = clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      ratio_ff <= ratio_in;
      zero_ff  <= zero_in;
      sat_ff   <= sat_in;
   end

   assign sts.zero_total = (total_ff == '0);
   assign ratio          = ratio_ff;
   assign zero_total     = zero_ff;
   assign saturated      = sat_ff;

endmodule

>>> rtl/wfot_ctrl.sv
module wfot_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_row,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  wfot_pkg::status_type sts,
   output wfot_pkg::cmd_type    cmd
);

   wfot_pkg::state_type          state_ff, state_in;
   logic [wfot_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wfot_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      accept       = 1'b0;

      case (state_ff)
         wfot_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            accept         = req_valid;
            cmd.accumulate = accept;
            if (accept && req_last_row)
               state_in = wfot_pkg::ST_TOTAL;
         end
         wfot_pkg::ST_TOTAL: begin
            cmd.calc_total = 1'b1;
            state_in       = wfot_pkg::ST_PREP;
         end
         wfot_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = sts.zero_total ? wfot_pkg::ST_FINISH : wfot_pkg::ST_DIV;
         end
         wfot_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == wfot_pkg::STEP_W'(wfot_pkg::DIV_W - 1))
               state_in = wfot_pkg::ST_FINISH;
         end
         wfot_pkg::ST_FINISH: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = wfot_pkg::ST_IDLE;
            end
         end
         default: state_in = wfot_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> tb/sv/tb_weighted_fraction_over_threshold_top.sv
`timescale 1ns / 100ps

module tb_weighted_fraction_over_threshold_top;

   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ROWS  = 350;
   localparam logic [wfot_pkg::REG_IDX_W-1:0]    REG_SPARE = 2'd3;
   localparam logic signed [wfot_pkg::SCORE_W-1:0] SCORE_MAX = 16'sh7fff;
   localparam logic signed [wfot_pkg::SCORE_W-1:0] SCORE_MIN = 16'sh8000;

   typedef struct {
      logic signed [wfot_pkg::SCORE_W-1:0] score;
      logic                                last_row;
   } row_type;

   typedef struct {
      logic signed [wfot_pkg::RATIO_W-1:0] ratio;
      logic                                zero_total;
      logic                                saturated;
   } ratio_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [wfot_pkg::REG_IDX_W-1:0] csr_index = '0;
   logic [wfot_pkg::CSR_W-1:0]     csr_wdata = '0;

   wfot_req_if req_bus ();
   wfot_rsp_if rsp_bus ();

   weighted_fraction_over_threshold_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   row_type   pending_rows[$];
   ratio_type expected_ratios[$];
   int        mismatch_count = 0;
   int        random_rows = 0;
   int        send_idle_pct = 36;
   int        recv_idle_pct = 50;
   logic      hold_go = 1'b0;
   logic      hold_done = 1'b0;
   int        hold_left = 0;

   // shadow of the block's registers and column accumulators
   logic signed [wfot_pkg::SCORE_W-1:0] cfg_threshold = '0;
   logic [wfot_pkg::MODE_W-1:0]         cfg_mode = wfot_pkg::MODE_RAW;
   logic signed [wfot_pkg::SCORE_W-1:0] cfg_shift = '0;
   longint                              col_sum_all = 0;
   longint                              col_sum_over = 0;
   int                                  col_rows = 0;
   int                                  col_rows_over = 0;
   longint                              col_min = 32767;

   always #2 clock = ~clock;

   function automatic void fold_row(input logic signed [wfot_pkg::SCORE_W-1:0] score,
                                    input logic last_row);
      longint               s, w, shift, total, over_w, num, den;
      longint unsigned      a, b, q;
      logic                 neg;
      ratio_type            r;
      s = score;
      // rows past the row limit and rows in unused modes add nothing
      if (col_rows < wfot_pkg::MAX_ROWS && cfg_mode <= wfot_pkg::MODE_GSHIFT) begin
         w = (cfg_mode == wfot_pkg::MODE_ABS && s < 0) ? -s : s;
         col_sum_all += w;
         col_rows++;
         if (s >= cfg_threshold) begin
            col_sum_over += w;
            col_rows_over++;
         end
         if (s < col_min) col_min = s;
      end
      if (!last_row) return;

      shift = 0;
      if (cfg_mode == wfot_pkg::MODE_LMIN) shift = col_min;
      else if (cfg_mode == wfot_pkg::MODE_GSHIFT) shift = longint'(cfg_shift);
      total  = col_sum_all - longint'(col_rows) * shift;
      over_w = col_sum_over - longint'(col_rows_over) * shift;
      col_sum_all   = 0;
      col_sum_over  = 0;
      col_rows      = 0;
      col_rows_over = 0;
      col_min       = 32767;

      r.ratio      = '0;
      r.zero_total = 1'b0;
      r.saturated  = 1'b0;
      if (total == 0) begin
         r.zero_total = 1'b1;
      end else begin
         num = (cfg_mode == wfot_pkg::MODE_UNDER) ? 2 * total - over_w : over_w;
         den = total;
         neg = (num < 0) != (den < 0);
         a = (num < 0) ? -num : num;
         b = (den < 0) ? -den : den;
         // Q15.16, round half away from zero
         q = (a * 64'd131072 + b) / (64'd2 * b);
         if (neg && q > 64'd2147483648) begin
            q = 64'd2147483648;
            r.saturated = 1'b1;
         end else if (!neg && q > 64'd2147483647) begin
            q = 64'd2147483647;
            r.saturated = 1'b1;
         end
         r.ratio = q[wfot_pkg::RATIO_W-1:0];
         if (neg) r.ratio = -r.ratio;
      end
      expected_ratios.insert(expected_ratios.size(), r);
   endfunction

   function automatic logic signed [wfot_pkg::SCORE_W-1:0] clip_score(input longint v);
      if (v > 32767) return SCORE_MAX;
      if (v < -32768) return SCORE_MIN;
      return v[wfot_pkg::SCORE_W-1:0];
   endfunction

   function automatic logic signed [wfot_pkg::SCORE_W-1:0] pick_score();
      logic [wfot_pkg::SCORE_W-1:0] bits;
      bits = wfot_pkg::SCORE_W'($urandom());
      case ($urandom_range(0, 5))
         0, 1: return bits;
         2: return clip_score(int'($urandom_range(0, 40)) - 20);
         3: begin
            case ($urandom_range(0, 3))
               0: return SCORE_MIN;
               1: return SCORE_MIN + 16'sd1;
               2: return SCORE_MAX - 16'sd1;
               default: return SCORE_MAX;
            endcase
         end
         4: return clip_score(longint'(cfg_threshold) + int'($urandom_range(0, 4)) - 2);
         default: return clip_score(int'($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_rows.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_bus.valid    <= 1'b1;
            req_bus.score    <= pending_rows[0].score;
            req_bus.last_row <= pending_rows[0].last_row;
            void'(pending_rows.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // predict on every accepted row transaction
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         fold_row(req_bus.score, req_bus.last_row);
   end

   // one long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_ratios.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual ratio %0d zero %0b sat %0b",
                     $time, rsp_bus.ratio, rsp_bus.zero_total, rsp_bus.saturated);
            mismatch_count++;
         end else begin
            if (rsp_bus.ratio !== expected_ratios[0].ratio) begin
               $display("%0t: ratio expected %0d actual %0d",
                        $time, expected_ratios[0].ratio, rsp_bus.ratio);
               mismatch_count++;
            end
            if (rsp_bus.zero_total !== expected_ratios[0].zero_total) begin
               $display("%0t: zero_total expected %0b actual %0b",
                        $time, expected_ratios[0].zero_total, rsp_bus.zero_total);
               mismatch_count++;
            end
            if (rsp_bus.saturated !== expected_ratios[0].saturated) begin
               $display("%0t: saturated expected %0b actual %0b",
                        $time, expected_ratios[0].saturated, rsp_bus.saturated);
               mismatch_count++;
            end
            void'(expected_ratios.pop_front());
         end
      end
   end

   task automatic write_reg(input logic [wfot_pkg::REG_IDX_W-1:0] idx,
                            input logic [wfot_pkg::CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         wfot_pkg::REG_THRESHOLD:    cfg_threshold = data;
         wfot_pkg::REG_WEIGHT_MODE:  cfg_mode = data[wfot_pkg::MODE_W-1:0];
         wfot_pkg::REG_GLOBAL_SHIFT: cfg_shift = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_row(input logic signed [wfot_pkg::SCORE_W-1:0] score,
                           input logic last_row);
      row_type r;
      r.score    = score;
      r.last_row = last_row;
      pending_rows.insert(pending_rows.size(), r);
   endtask

   // all rows taken, all results seen, then let the divider settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_rows.size() != 0 || req_bus.valid || expected_ratios.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic randomize_config();
      logic [wfot_pkg::CSR_W-1:0]  data;
      logic [wfot_pkg::MODE_W-1:0] m;
      if ($urandom_range(0, 1)) begin
         data = wfot_pkg::CSR_W'($urandom());
         case ($urandom_range(0, 4))
            0: data = SCORE_MIN;
            1: data = SCORE_MAX;
            2: data = '0;
            3: ;
            default: data = clip_score(int'($urandom_range(0, 100)) - 50);
         endcase
         write_reg(wfot_pkg::REG_THRESHOLD, data);
      end
      if ($urandom_range(0, 2) != 0) begin
         m = wfot_pkg::MODE_W'(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7)
                                                            : $urandom_range(0, 4));
         data = wfot_pkg::CSR_W'($urandom());
         data[wfot_pkg::MODE_W-1:0] = m;
         write_reg(wfot_pkg::REG_WEIGHT_MODE, data);
      end
      if ($urandom_range(0, 1)) begin
         data = wfot_pkg::CSR_W'($urandom());
         case ($urandom_range(0, 3))
            0: data = SCORE_MIN;
            1: data = SCORE_MAX;
            2: ;
            default: data = clip_score(int'($urandom_range(0, 200)) - 100);
         endcase
         write_reg(wfot_pkg::REG_GLOBAL_SHIFT, data);
      end
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, wfot_pkg::CSR_W'($urandom()));
   endtask

   // styles: mixed, balanced tail (tiny total), repeated value, mirrored pairs
   task automatic queue_column(input logic leave_open);
      int                                  len, style;
      longint                              run_sum;
      logic signed [wfot_pkg::SCORE_W-1:0] sc, first_sc, prev_sc;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      style = $urandom_range(0, 3);
      run_sum = 0;
      first_sc = pick_score();
      prev_sc = first_sc;
      for (int i = 0; i < len; i++) begin
         sc = pick_score();
         if (i == 0) sc = first_sc;
         else if (style == 2) sc = first_sc;
         else if (style == 3 && i % 2 == 1) sc = clip_score(-longint'(prev_sc));
         else if (style == 1 && i == len - 1)
            sc = clip_score(-run_sum + int'($urandom_range(0, 4)) - 2);
         run_sum += sc;
         prev_sc = sc;
         push_row(sc, (i == len - 1) && !leave_open);
         random_rows++;
      end
   endtask

   initial begin
      int n_cols;
      req_bus.valid    = 1'b0;
      req_bus.score    = '0;
      req_bus.last_row = 1'b0;
      rsp_bus.ready    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // raw mode, threshold 0: positive saturation, zero sums, negative ratio
      push_row(SCORE_MAX, 1'b0);
      push_row(SCORE_MAX, 1'b0);
      push_row(-16'sd32767, 1'b0);
      push_row(-16'sd32766, 1'b1);
      push_row(16'sd5, 1'b0);
      push_row(-16'sd5, 1'b1);
      push_row(16'sd0, 1'b1);
      push_row(SCORE_MIN, 1'b0);
      push_row(16'sd100, 1'b1);
      wait_drained();

      // two minus ratio: negative saturation
      write_reg(wfot_pkg::REG_WEIGHT_MODE, wfot_pkg::CSR_W'(wfot_pkg::MODE_UNDER));
      @(negedge clock);
      push_row(SCORE_MAX, 1'b0);
      push_row(SCORE_MAX, 1'b0);
      push_row(-16'sd32767, 1'b0);
      push_row(-16'sd32766, 1'b1);
      push_row(16'sd10, 1'b0);
      push_row(-16'sd3, 1'b1);
      wait_drained();

      write_reg(wfot_pkg::REG_THRESHOLD, SCORE_MIN);
      write_reg(wfot_pkg::REG_WEIGHT_MODE, wfot_pkg::CSR_W'(wfot_pkg::MODE_ABS));
      @(negedge clock);
      push_row(SCORE_MIN, 1'b0);
      push_row(SCORE_MAX, 1'b1);
      wait_drained();

      write_reg(wfot_pkg::REG_THRESHOLD, SCORE_MAX);
      write_reg(wfot_pkg::REG_WEIGHT_MODE, wfot_pkg::CSR_W'(wfot_pkg::MODE_LMIN));
      @(negedge clock);
      push_row(16'sd7, 1'b0);
      push_row(16'sd7, 1'b1);
      push_row(SCORE_MIN, 1'b0);
      push_row(SCORE_MAX, 1'b1);
      wait_drained();

      write_reg(wfot_pkg::REG_WEIGHT_MODE, wfot_pkg::CSR_W'(wfot_pkg::MODE_GSHIFT));
      write_reg(wfot_pkg::REG_GLOBAL_SHIFT, SCORE_MAX);
      @(negedge clock);
      push_row(SCORE_MAX, 1'b0);
      push_row(SCORE_MIN, 1'b1);
      wait_drained();

      // unused modes carry no weight
      write_reg(wfot_pkg::REG_WEIGHT_MODE, 16'd5);
      @(negedge clock);
      push_row(16'sd1, 1'b1);
      wait_drained();
      write_reg(wfot_pkg::REG_WEIGHT_MODE, 16'hffff);
      @(negedge clock);
      push_row(SCORE_MAX, 1'b1);
      wait_drained();

      // row limit: a column whose rows past the limit must be ignored
      write_reg(wfot_pkg::REG_THRESHOLD, 16'd0);
      write_reg(wfot_pkg::REG_WEIGHT_MODE, wfot_pkg::CSR_W'(wfot_pkg::MODE_LMIN));
      @(negedge clock);
      for (int i = 0; i < wfot_pkg::MAX_ROWS; i++)
         push_row(clip_score(int'($urandom_range(0, 2000)) - 1000), 1'b0);
      push_row(SCORE_MIN, 1'b0);
      push_row(SCORE_MIN, 1'b0);
      push_row(SCORE_MIN, 1'b1);
      wait_drained();

      while (random_rows < RANDOM_ROWS) begin
         randomize_config();
         @(negedge clock);
         if (random_rows < RANDOM_ROWS / 3) begin
            send_idle_pct = 36;
            recv_idle_pct = 50;
         end else if (random_rows < 2 * RANDOM_ROWS / 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         hold_go <= 1'b1;
         n_cols = $urandom_range(4, 14);
         // sometimes leave the column open across the next register writes
         for (int c = 0; c < n_cols; c++)
            queue_column(c == n_cols - 1 && $urandom_range(0, 3) == 0);
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("weighted_fraction_over_threshold_top: match");
      else
         $display("weighted_fraction_over_threshold_top: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("weighted_fraction_over_threshold_top: mismatch");
      $finish;
   end

endmodule
